@@ design/sprc_pkg.sv @@
`timescale 1ns / 1ps

package sprc_pkg;

  localparam int SPEED_BITS_DEF = 16;
  localparam int PHASE_BITS_DEF = 16;

  // Width of the register index on the configuration channel.
  localparam int CFG_INDEX_BITS = 3;

  // Bit of the run mode that marks the spindle as turning.
  localparam int RUN_ON_BIT = 0;

  localparam logic [1:0] RUN_OFF    = 2'd0;
  localparam logic [1:0] RUN_ON     = 2'd1;
  localparam logic [1:0] RUN_PAUSED = 2'd2;

  typedef enum logic [2:0] {
    FN_SPEED   = 3'd0,
    FN_OFF     = 3'd1,
    FN_ON_CW   = 3'd2,
    FN_ON_CCW  = 3'd3,
    FN_PAUSE   = 3'd4,
    FN_RESUME  = 3'd5,
    FN_RESET   = 3'd6,
    FN_SET_DIR = 3'd7
  } func_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_CW_SPEED  = 3'd0,
    CFG_CW_PHASE  = 3'd1,
    CFG_CCW_SPEED = 3'd2,
    CFG_CCW_PHASE = 3'd3,
    CFG_OFF_PHASE = 3'd4,
    CFG_EN_HIGH   = 3'd5,
    CFG_CW_HIGH   = 3'd6
  } cfg_idx_t;

  // Strobes from the controller to the datapath.
  typedef struct packed {
    logic apply;
    logic prep;
    logic mul;
    logic div_start;
    logic div_step;
    logic load_out;
  } ctl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic div_last;
  } ctl_status_t;

endpackage

@@ design/sprc_cmd_if.sv @@
`timescale 1ns / 1ps

interface sprc_cmd_if #(
  parameter int SPEED_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            func;
  logic [SPEED_BITS-1:0] speed_rpm;
  logic                  direction_sel;
  logic                  pause_option;
  logic [15:0]           dwell_tenths;

  modport source (
    output valid, func, speed_rpm, direction_sel, pause_option, dwell_tenths,
    input  ready
  );

  modport sink (
    input  valid, func, speed_rpm, direction_sel, pause_option, dwell_tenths,
    output ready
  );
endinterface

@@ design/sprc_res_if.sv @@
`timescale 1ns / 1ps

interface sprc_res_if #(
  parameter int SPEED_BITS = 16,
  parameter int PHASE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [PHASE_BITS-1:0] duty;
  logic                  enable_pin;
  logic                  direction_pin;
  logic [1:0]            run_state;
  logic                  direction_now;
  logic [SPEED_BITS-1:0] stored_speed;
  logic                  dwell_request;
  logic [15:0]           dwell_out;

  modport source (
    output valid, duty, enable_pin, direction_pin, run_state, direction_now,
           stored_speed, dwell_request, dwell_out,
    input  ready
  );

  modport sink (
    input  valid, duty, enable_pin, direction_pin, run_state, direction_now,
           stored_speed, dwell_request, dwell_out,
    output ready
  );
endinterface

@@ design/sprc_cfg_if.sv @@
`timescale 1ns / 1ps

interface sprc_cfg_if #(
  parameter int INDEX_BITS = 3,
  parameter int DATA_BITS  = 32
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] index;
  logic [DATA_BITS-1:0]  data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

@@ design/sprc_ctrl.sv @@
`timescale 1ns / 1ps

module sprc_ctrl
  import sprc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output ctl_cmd_t    ctl,
  input  ctl_status_t status
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    ctl           = '0;
    ctl.apply     = in_valid && (state == ST_IDLE);
    ctl.prep      = (state == ST_PREP);
    ctl.mul       = (state == ST_MUL);
    ctl.div_start = (state == ST_LOAD);
    ctl.div_step  = (state == ST_DIV);
    ctl.load_out  = (state == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // In the done state a taken result is replaced by the next one.
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: state <= ST_MUL;
        ST_MUL:  state <= ST_LOAD;
        ST_LOAD: state <= ST_DIV;
        ST_DIV: begin
          if (status.div_last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ design/sprc_datapath.sv @@
`timescale 1ns / 1ps

module sprc_datapath
  import sprc_pkg::*;
#(
  parameter int SPEED_BITS = SPEED_BITS_DEF,
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int CFG_BITS   = 2 * SPEED_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ctl_cmd_t                  ctl,
  output ctl_status_t               status,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  input  logic [2:0]                func,
  input  logic [SPEED_BITS-1:0]     speed_rpm,
  input  logic                      direction_sel,
  input  logic                      pause_option,
  input  logic [15:0]               dwell_tenths,
  output logic [PHASE_BITS-1:0]     duty,
  output logic                      enable_pin,
  output logic                      direction_pin,
  output logic [1:0]                run_state,
  output logic                      direction_now,
  output logic [SPEED_BITS-1:0]     stored_speed,
  output logic                      dwell_request,
  output logic [15:0]               dwell_out
);

  localparam int SB       = SPEED_BITS;
  localparam int PB       = PHASE_BITS;
  localparam int NB       = SB + PB;
  localparam int CNT_BITS = $clog2(PB);

  // Configuration registers.
  logic [2*SB-1:0] cw_spd;
  logic [2*PB-1:0] cw_ph;
  logic [2*SB-1:0] ccw_spd;
  logic [2*PB-1:0] ccw_ph;
  logic [PB-1:0]   off_ph;
  logic            en_high;
  logic            cw_high;

  // Spindle state.
  logic [1:0]      run_mode;
  logic            spin_dir;
  logic [SB-1:0]   speed;
  logic            req;
  logic [15:0]     dwell;

  // Operands captured for the duty map.
  logic [SB-1:0]   ofs_r;
  logic [SB-1:0]   den_r;
  logic [PB-1:0]   mag_r;
  logic [PB-1:0]   plo_r;
  logic [PB-1:0]   phi_r;
  logic            up_r;
  logic            eq_r;
  logic            lt_r;
  logic [NB-1:0]   prod;

  // Divider.
  logic [SB-1:0]       rem;
  logic [PB-1:0]       qsh;
  logic [CNT_BITS-1:0] cnt;

  logic [2*SB-1:0] sr;
  logic [2*PB-1:0] pr;
  logic [SB-1:0]   slo;
  logic [SB-1:0]   shi;
  logic [PB-1:0]   plo;
  logic [PB-1:0]   phi;
  logic [SB-1:0]   s_lo_cl;
  logic [SB-1:0]   s_cl;
  logic [NB-1:0]   dvd;
  logic [SB:0]     trial;
  logic            ge;
  logic [PB-1:0]   q_cl;
  logic [PB-1:0]   duty_next;

  always_comb begin
    sr      = spin_dir ? ccw_spd : cw_spd;
    pr      = spin_dir ? ccw_ph : cw_ph;
    slo     = sr[SB-1:0];
    shi     = sr[2*SB-1:SB];
    plo     = pr[PB-1:0];
    phi     = pr[2*PB-1:PB];
    s_lo_cl = (speed < slo) ? slo : speed;
    s_cl    = (s_lo_cl > shi) ? shi : s_lo_cl;
  end

  // Rounded quotient: half the divisor is added before dividing.
  assign dvd   = prod + NB'(den_r >> 1);
  assign trial = {rem, qsh[PB-1]};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    q_cl = (qsh > mag_r) ? mag_r : qsh;
    if (run_mode != RUN_ON) begin
      duty_next = off_ph;
    end else if (eq_r) begin
      duty_next = plo_r;
    end else if (lt_r) begin
      duty_next = phi_r;
    end else if (up_r) begin
      duty_next = plo_r + q_cl;
    end else begin
      duty_next = plo_r - q_cl;
    end
  end

  assign status.div_last = (cnt == CNT_BITS'(PB - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cw_spd  <= {{SB{1'b1}}, {SB{1'b0}}};
      ccw_spd <= {{SB{1'b1}}, {SB{1'b0}}};
      cw_ph   <= {{PB{1'b1}}, {PB{1'b0}}};
      ccw_ph  <= {{PB{1'b1}}, {PB{1'b0}}};
      off_ph  <= '0;
      en_high <= 1'b0;
      cw_high <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CW_SPEED:  cw_spd  <= cfg_data[2*SB-1:0];
        CFG_CW_PHASE:  cw_ph   <= cfg_data[2*PB-1:0];
        CFG_CCW_SPEED: ccw_spd <= cfg_data[2*SB-1:0];
        CFG_CCW_PHASE: ccw_ph  <= cfg_data[2*PB-1:0];
        CFG_OFF_PHASE: off_ph  <= cfg_data[PB-1:0];
        CFG_EN_HIGH:   en_high <= cfg_data[0];
        CFG_CW_HIGH:   cw_high <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode <= RUN_OFF;
      spin_dir <= 1'b0;
      speed    <= '0;
      req      <= 1'b0;
      dwell    <= '0;
    end else if (ctl.apply) begin
      req   <= 1'b0;
      dwell <= '0;
      case (func_t'(func))
        FN_SPEED:  speed <= speed_rpm;
        FN_OFF:    run_mode <= RUN_OFF;
        FN_ON_CW: begin
          run_mode <= RUN_ON;
          spin_dir <= 1'b0;
        end
        FN_ON_CCW: begin
          run_mode <= RUN_ON;
          spin_dir <= 1'b1;
        end
        FN_PAUSE: begin
          if (pause_option && (run_mode == RUN_ON)) begin
            run_mode <= RUN_PAUSED;
          end
        end
        FN_RESUME: begin
          if (run_mode == RUN_PAUSED) begin
            run_mode <= RUN_ON;
            req      <= 1'b1;
            dwell    <= dwell_tenths;
          end
        end
        FN_RESET: begin
          speed    <= '0;
          run_mode <= RUN_OFF;
          spin_dir <= 1'b0;
        end
        FN_SET_DIR: spin_dir <= direction_sel;
        default: ;
      endcase
    end else if (ctl.prep && (run_mode == RUN_ON)) begin
      // The clamped speed is kept whenever the spindle is on.
      speed <= s_cl;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.prep) begin
      ofs_r <= s_cl - slo;
      den_r <= shi - slo;
      up_r  <= (phi >= plo);
      mag_r <= (phi >= plo) ? (phi - plo) : (plo - phi);
      plo_r <= plo;
      phi_r <= phi;
      eq_r  <= (shi == slo);
      lt_r  <= (shi < slo);
    end
    if (ctl.mul) begin
      prod <= ofs_r * mag_r;
    end
  end

  // Restoring division, one quotient bit a cycle. The upper part of the
  // dividend is known to stay below the divisor, so only PB bits remain.
  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      rem <= dvd[NB-1:PB];
      qsh <= dvd[PB-1:0];
      cnt <= '0;
    end else if (ctl.div_step) begin
      rem <= ge ? SB'(trial - {1'b0, den_r}) : trial[SB-1:0];
      qsh <= {qsh[PB-2:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      duty          <= duty_next;
      enable_pin    <= ~(run_mode[RUN_ON_BIT] ^ en_high);
      direction_pin <= spin_dir ^ cw_high;
      run_state     <= run_mode;
      direction_now <= spin_dir;
      stored_speed  <= speed;
      dwell_request <= req;
      dwell_out     <= dwell;
    end
  end

endmodule

@@ design/spindle_run_control_pwm_map.sv @@
`timescale 1ns / 1ps

// Channel   Role    Signals
// cmd       sink    valid, ready, func, speed_rpm, direction_sel, pause_option, dwell_tenths
// res       source  valid, ready, duty, enable_pin, direction_pin, run_state,
//                   direction_now, stored_speed, dwell_request, dwell_out
// cfg       sink    valid, ready, index, data (register write, always ready)
//
// Each command transaction is accepted and applied to the spindle state, then
// passes through operand capture, multiplication, divider load, the bit-serial
// division and the output load. Commands are not overlapped: the next one is
// taken only after the previous transaction has left the controller's states.
// A new command is accepted once the previous result has moved to the output
// register, even while that result still waits for the sink.
// Reset is synchronous and active high; it restores the register defaults and
// leaves the spindle off, clockwise, at speed zero.

module spindle_run_control_pwm_map
  import sprc_pkg::*;
#(
  parameter int SPEED_BITS = SPEED_BITS_DEF,
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  sprc_cmd_if.sink cmd,
  sprc_res_if.source res,
  sprc_cfg_if.sink cfg
);

  // The configuration data word is wide enough for the widest range register.
  localparam int CFG_BITS = (SPEED_BITS > PHASE_BITS) ? 2 * SPEED_BITS : 2 * PHASE_BITS;

  ctl_cmd_t    ctl;
  ctl_status_t status;
  logic        cmd_ready;
  logic        res_valid;

  // Configuration writes are taken in any cycle.
  assign cfg.ready = 1'b1;
  assign cmd.ready = cmd_ready;
  assign res.valid = res_valid;

  // The controller sequences one command through state update, operand
  // capture, multiplication and division, then loads the output register.
  sprc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd_ready),
    .out_valid (res_valid),
    .out_ready (res.ready),
    .ctl       (ctl),
    .status    (status)
  );

  // The datapath holds the configuration, the spindle state and the
  // duty map arithmetic together with the result register.
  sprc_datapath #(
    .SPEED_BITS (SPEED_BITS),
    .PHASE_BITS (PHASE_BITS),
    .CFG_BITS   (CFG_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .status        (status),
    .cfg_write     (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .func          (cmd.func),
    .speed_rpm     (cmd.speed_rpm),
    .direction_sel (cmd.direction_sel),
    .pause_option  (cmd.pause_option),
    .dwell_tenths  (cmd.dwell_tenths),
    .duty          (res.duty),
    .enable_pin    (res.enable_pin),
    .direction_pin (res.direction_pin),
    .run_state     (res.run_state),
    .direction_now (res.direction_now),
    .stored_speed  (res.stored_speed),
    .dwell_request (res.dwell_request),
    .dwell_out     (res.dwell_out)
  );

endmodule
